// ----- hdl/scov_pkg.sv -----
// ----------------------------------------------------------------------------
// scov_pkg
// shared constants, register codes and types of the sample covariance engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scov_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int MAX_LENGTH  = 64;

  localparam int SIDX_W = $clog2(MAX_SAMPLES);
  localparam int EIDX_W = $clog2(MAX_LENGTH);
  localparam int ADDR_W = SIDX_W + EIDX_W;
  localparam int DATA_W = 32;
  localparam int CNT_W  = SIDX_W + 1;
  localparam int LEN_W  = EIDX_W + 1;

  // column sum, scaled deviation, deviation magnitude, product magnitude, accumulator
  localparam int SUM_W  = DATA_W + SIDX_W;
  localparam int DEV_W  = SUM_W + 1;
  localparam int DMAG_W = SUM_W;
  localparam int PMAG_W = 2 * DMAG_W;
  localparam int ACC_W  = PMAG_W + SIDX_W + 2;
  localparam int QW     = 128;

  localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd0;
  localparam logic [2:0] REG_VECTOR_LENGTH = 3'd1;
  localparam logic [2:0] REG_NOISE_SPAN    = 3'd2;
  localparam logic [2:0] REG_COMPAT_MODE   = 3'd3;
  localparam logic [2:0] REG_PREWHITEN     = 3'd4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [LEN_W-1:0] len;
    logic             compat;
    logic             prewhiten;
  } cfg_t;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/scov_store.sv -----
// ----------------------------------------------------------------------------
// scov_store
// sample memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scov_store (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [scov_pkg::ADDR_W-1:0] waddr,
  input  wire logic [scov_pkg::DATA_W-1:0] wdata,
  input  wire logic [scov_pkg::ADDR_W-1:0] raddr,
  output logic      [scov_pkg::DATA_W-1:0] rdata
);

  logic [scov_pkg::DATA_W-1:0] mem [scov_pkg::MAX_SAMPLES*scov_pkg::MAX_LENGTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/scov_div.sv -----
// ----------------------------------------------------------------------------
// scov_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scov_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [scov_pkg::QW-1:0] num,
  input  wire logic [scov_pkg::QW-1:0] den,
  output logic                         done,
  output logic      [scov_pkg::QW-1:0] quo
);

  localparam int CW = $clog2(scov_pkg::QW);

  logic                    busy_r, done_r;
  logic [CW-1:0]           cnt_r;
  logic [scov_pkg::QW-1:0] rem_r, qn_r, den_r;
  logic [scov_pkg::QW-1:0] rsh;
  logic                    ge;

  assign rsh = {rem_r[scov_pkg::QW-2:0], qn_r[scov_pkg::QW-1]};
  assign ge  = (rsh >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(scov_pkg::QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn_r  <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rsh - den_r : rsh;
      qn_r  <= {qn_r[scov_pkg::QW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = qn_r;

endmodule

`default_nettype wire

// ----- hdl/scov_sqrt.sv -----
// ----------------------------------------------------------------------------
// scov_sqrt
// integer square root of a 64-bit word, one root bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scov_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic      [31:0] root
);

  logic        busy_r, done_r;
  logic [63:0] bit_r, r_r, x_r;
  logic [63:0] t;

  assign t = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (x_r >= t) begin
        x_r <= x_r - t;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

`default_nettype wire

// ----- hdl/scov_engine.sv -----
// ----------------------------------------------------------------------------
// scov_engine
// query sequencer around one shared 32x32 multiplier, divider and root unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scov_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [scov_pkg::EIDX_W-1:0] row,
  input  wire logic [scov_pkg::EIDX_W-1:0] col,
  input  wire scov_pkg::cfg_t              cfg,
  output logic                             idle,
  output logic      [scov_pkg::ADDR_W-1:0] raddr,
  input  wire logic [scov_pkg::DATA_W-1:0] rdata,
  output logic                             res_valid,
  output scov_pkg::res_t                   res,
  input  wire logic                        res_ack
);

  localparam int SW  = scov_pkg::SIDX_W;
  localparam int EW  = scov_pkg::EIDX_W;
  localparam int CW  = scov_pkg::CNT_W;
  localparam int SMW = scov_pkg::SUM_W;
  localparam int DW  = scov_pkg::DEV_W;
  localparam int MW  = scov_pkg::DMAG_W;
  localparam int PW  = scov_pkg::PMAG_W;
  localparam int AW  = scov_pkg::ACC_W;
  localparam int QW  = scov_pkg::QW;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SUM_A = 5'd1;
  localparam logic [4:0] ST_SUM_B = 5'd2;
  localparam logic [4:0] ST_SUM_C = 5'd3;
  localparam logic [4:0] ST_X_RJ  = 5'd4;
  localparam logic [4:0] ST_X_RK  = 5'd5;
  localparam logic [4:0] ST_X_DJ  = 5'd6;
  localparam logic [4:0] ST_X_DK  = 5'd7;
  localparam logic [4:0] ST_X_MUL = 5'd8;
  localparam logic [4:0] ST_X_ACC = 5'd9;
  localparam logic [4:0] ST_FIN   = 5'd10;
  localparam logic [4:0] ST_DEN_A = 5'd11;
  localparam logic [4:0] ST_DEN_B = 5'd12;
  localparam logic [4:0] ST_DEN_C = 5'd13;
  localparam logic [4:0] ST_NRM   = 5'd14;
  localparam logic [4:0] ST_SQ_W  = 5'd15;
  localparam logic [4:0] ST_RR_A  = 5'd16;
  localparam logic [4:0] ST_RR_B  = 5'd17;
  localparam logic [4:0] ST_DIV_W = 5'd18;
  localparam logic [4:0] ST_DONE  = 5'd19;

  logic [4:0]    state_r, state_nxt;
  logic [SW-1:0] i_r;
  logic [EW-1:0] j_r, k_r;
  logic [SMW-1:0] sj_r, sk_r;
  logic          xneg_r;
  logic [DW-1:0] dj_r, dk_r;
  logic [1:0]    pr_r;
  logic [2:0]    pc_r;
  logic [PW-1:0] pm_r;
  logic [AW-1:0] pjk_r, pjj_r, pkk_r;
  logic [AW-1:0] nrm_r;
  logic [7:0]    ns_r, sa_r, sb_r, sc_r;
  logic [1:0]    nsel_r;
  logic [31:0]   ra_r, rb_r;
  logic [61:0]   cm_r;
  logic [63:0]   prod_r;
  logic          neg_r;
  scov_pkg::res_t res_r;

  logic [SW-1:0] nm1, first;
  logic [31:0]   rmag, mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [DW-1:0] nx, dnew, da, db, amag_w, bmag_w;
  logic [MW-1:0] amag, bmag;
  logic [PW-1:0] pm_add;
  logic [AW-1:0] term, pmag_w;
  logic          ge62, lt60;
  logic [9:0]    sum_ab, e;
  logic          e_big;
  logic [QW-1:0] num_sh, den_sh, den_cov;
  logic          div_start, div_done;
  logic [QW-1:0] div_num, div_den, quo;
  logic          sq_start, sq_done;
  logic [31:0]   root;
  logic [63:0]   limit, qmag;
  logic          ovf;

  scov_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  scov_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     ({2'b00, nrm_r[61:0]}),
    .done  (sq_done),
    .root  (root)
  );

  assign nm1   = SW'(cfg.n - 1'b1);
  assign first = cfg.compat ? SW'(1) : SW'(0);
  assign rmag  = rdata[31] ? 32'(-rdata) : rdata;

  // scaled deviation n*x - s from the last product
  assign nx   = xneg_r ? DW'(-{1'b0, prod_r[DW-2:0]}) : {1'b0, prod_r[DW-2:0]};
  assign dnew = nx - ((state_r == ST_X_DJ) ? {sj_r[SMW-1], sj_r} : {sk_r[SMW-1], sk_r});

  assign da     = (pr_r == 2'd2) ? dk_r : dj_r;
  assign db     = (pr_r == 2'd1) ? dj_r : dk_r;
  assign amag_w = da[DW-1] ? DW'(-da) : da;
  assign bmag_w = db[DW-1] ? DW'(-db) : db;
  assign amag   = amag_w[MW-1:0];
  assign bmag   = bmag_w[MW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_X_RK, ST_X_DJ: begin
        mul_a = rmag;
        mul_b = 32'(cfg.n);
      end
      ST_X_MUL: begin
        case (pc_r)
          3'd0: begin
            mul_a = amag[31:0];
            mul_b = bmag[31:0];
          end
          3'd1: begin
            mul_a = amag[31:0];
            mul_b = 32'(bmag[MW-1:32]);
          end
          3'd2: begin
            mul_a = 32'(amag[MW-1:32]);
            mul_b = bmag[31:0];
          end
          3'd3: begin
            mul_a = 32'(amag[MW-1:32]);
            mul_b = 32'(bmag[MW-1:32]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_DEN_A: begin
        mul_a = 32'(cfg.n);
        mul_b = 32'(cfg.n);
      end
      ST_DEN_B: begin
        mul_a = prod_r[31:0];
        mul_b = cfg.compat ? 32'(cfg.n) : 32'(CW'(cfg.n - 1'b1));
      end
      ST_RR_A: begin
        mul_a = ra_r;
        mul_b = rb_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    case (pc_r)
      3'd1:    pm_add = PW'(prod_r);
      3'd2:    pm_add = PW'(prod_r) << 32;
      3'd3:    pm_add = PW'(prod_r) << 32;
      3'd4:    pm_add = PW'(prod_r) << 64;
      default: pm_add = '0;
    endcase
  end

  assign term   = AW'(pm_r);
  assign pmag_w = pjk_r[AW-1] ? AW'(-pjk_r) : pjk_r;

  assign ge62 = |nrm_r[AW-1:62];
  assign lt60 = ~|nrm_r[AW-1:60];

  // quotient exponent sc + 30 - (sa + sb) / 2
  assign sum_ab = {{2{sa_r[7]}}, sa_r} + {{2{sb_r[7]}}, sb_r};
  assign e      = {{2{sc_r[7]}}, sc_r} + 10'd30 - {sum_ab[9], sum_ab[9:1]};
  assign e_big  = !e[9] && (e[8:0] > 9'd64);
  assign num_sh = e[9] ? QW'(cm_r) : (QW'(cm_r) << e[6:0]);
  assign den_sh = e[9] ? (QW'(prod_r) << 7'(-e[6:0])) : QW'(prod_r);
  assign den_cov = QW'(prod_r[24:0]);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_r == ST_DEN_C) begin
      div_start = 1'b1;
      div_num   = QW'(pmag_w) + (den_cov >> 1);
      div_den   = den_cov;
    end else if (state_r == ST_RR_B && !e_big) begin
      div_start = 1'b1;
      div_num   = num_sh + (den_sh >> 1);
      div_den   = den_sh;
    end
  end

  assign sq_start = (state_r == ST_NRM) && !ge62 && !lt60 && (nsel_r != 2'd2);

  always_comb begin
    if (cfg.prewhiten) begin
      limit = neg_r ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    end else begin
      limit = neg_r ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    end
  end

  assign ovf  = (|quo[QW-1:64]) || (quo[63:0] > limit);
  assign qmag = ovf ? limit : quo[63:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (7'(row) >= cfg.len || 7'(col) >= cfg.len) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SUM_A;
          end
        end
      end
      ST_SUM_A: state_nxt = ST_SUM_B;
      ST_SUM_B: state_nxt = ST_SUM_C;
      ST_SUM_C: state_nxt = (i_r == nm1) ? ST_X_RJ : ST_SUM_A;
      ST_X_RJ:  state_nxt = ST_X_RK;
      ST_X_RK:  state_nxt = ST_X_DJ;
      ST_X_DJ:  state_nxt = ST_X_DK;
      ST_X_DK:  state_nxt = ST_X_MUL;
      ST_X_MUL: state_nxt = (pc_r == 3'd4) ? ST_X_ACC : ST_X_MUL;
      ST_X_ACC: begin
        if (cfg.prewhiten && pr_r != 2'd2) begin
          state_nxt = ST_X_MUL;
        end else if (i_r == nm1) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_X_RJ;
        end
      end
      ST_FIN: begin
        if (!cfg.prewhiten) begin
          state_nxt = ST_DEN_A;
        end else if (pjj_r == '0 || pkk_r == '0 || pjk_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_NRM;
        end
      end
      ST_DEN_A: state_nxt = ST_DEN_B;
      ST_DEN_B: state_nxt = ST_DEN_C;
      ST_DEN_C: state_nxt = ST_DIV_W;
      ST_NRM: begin
        if (!ge62 && !lt60) begin
          state_nxt = (nsel_r == 2'd2) ? ST_RR_A : ST_SQ_W;
        end
      end
      ST_SQ_W:  state_nxt = sq_done ? ST_NRM : ST_SQ_W;
      ST_RR_A:  state_nxt = ST_RR_B;
      ST_RR_B:  state_nxt = e_big ? ST_DONE : ST_DIV_W;
      ST_DIV_W: state_nxt = div_done ? ST_DONE : ST_DIV_W;
      ST_DONE:  state_nxt = res_ack ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      ST_IDLE: begin
        j_r   <= row;
        k_r   <= col;
        i_r   <= '0;
        sj_r  <= '0;
        sk_r  <= '0;
        res_r <= '0;
      end
      ST_SUM_B: sj_r <= sj_r + SMW'($signed(rdata));
      ST_SUM_C: begin
        sk_r <= sk_r + SMW'($signed(rdata));
        if (i_r == nm1) begin
          i_r   <= first;
          pjk_r <= '0;
          pjj_r <= '0;
          pkk_r <= '0;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      ST_X_RK: xneg_r <= rdata[31];
      ST_X_DJ: begin
        dj_r   <= dnew;
        xneg_r <= rdata[31];
      end
      ST_X_DK: begin
        dk_r <= dnew;
        pr_r <= '0;
        pc_r <= '0;
      end
      ST_X_MUL: begin
        pm_r <= (pc_r == 3'd0) ? '0 : pm_r + pm_add;
        pc_r <= pc_r + 1'b1;
      end
      ST_X_ACC: begin
        case (pr_r)
          2'd0:    pjk_r <= (da[DW-1] ^ db[DW-1]) ? pjk_r - term : pjk_r + term;
          2'd1:    pjj_r <= pjj_r + term;
          default: pkk_r <= pkk_r + term;
        endcase
        pc_r <= '0;
        if (cfg.prewhiten && pr_r != 2'd2) begin
          pr_r <= pr_r + 1'b1;
        end else if (i_r != nm1) begin
          i_r <= i_r + 1'b1;
        end
      end
      ST_FIN: begin
        neg_r  <= pjk_r[AW-1];
        nrm_r  <= pjj_r;
        ns_r   <= '0;
        nsel_r <= '0;
        res_r.value <= '0;
        res_r.sat   <= cfg.prewhiten && (pjj_r == '0 || pkk_r == '0);
      end
      ST_NRM: begin
        if (ge62) begin
          nrm_r <= nrm_r >> 2;
          ns_r  <= ns_r + 8'd2;
        end else if (lt60) begin
          nrm_r <= nrm_r << 2;
          ns_r  <= ns_r - 8'd2;
        end else begin
          case (nsel_r)
            2'd0:    sa_r <= ns_r;
            2'd1:    sb_r <= ns_r;
            default: begin
              sc_r <= ns_r;
              cm_r <= nrm_r[61:0];
            end
          endcase
        end
      end
      ST_SQ_W: begin
        if (sq_done) begin
          if (nsel_r == 2'd0) begin
            ra_r  <= root;
            nrm_r <= pkk_r;
          end else begin
            rb_r  <= root;
            nrm_r <= pmag_w;
          end
          ns_r   <= '0;
          nsel_r <= nsel_r + 1'b1;
        end
      end
      ST_RR_B: begin
        res_r.value <= neg_r ? 64'(-limit) : limit;
        res_r.sat   <= 1'b1;
      end
      ST_DIV_W: begin
        res_r.value <= neg_r ? 64'(-qmag) : qmag;
        res_r.sat   <= ovf;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (state_r)
      ST_SUM_B, ST_X_RK: raddr = {i_r, k_r};
      default:           raddr = {i_r, j_r};
    endcase
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire

// ----- hdl/sample_covariance_engine_top.sv -----
// ----------------------------------------------------------------------------
// sample_covariance_engine_top
// covariance and correlation matrix entries of stored sample vectors
// ----------------------------------------------------------------------------
// in_*: stream of words; tuser = func (0 load, 1 query), tdata fields from
//   bit 0: sample_index, element_index, column_index, sample_value, shot_noise.
// out_*: one word per query; tdata = entry_value, tuser = saturated.
// cfg_*: register port, registers at byte addresses 0, 4, 8, 12, 16.
// a load is written to sample storage and in_tready stays high.
// a query holds in_tready low while it runs: the column sums, then one
//   deviation product (covariance) or three (correlation) per summed sample,
//   all on the one shared 32x32 multiplier, then the bit-serial divider;
//   correlation adds normalize steps and two square roots before the divide.
// a query whose row or column is outside the matrix is not computed; it returns 0.
// the result sits in the output register until taken; a stalled receiver
//   holds the engine at its last step and in_tready stays low meanwhile.
// reset clears the registers to their defaults and empties the output;
//   sample storage is not cleared and must be loaded before it is queried.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_covariance_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // sample_index, element_index, column_index,
                                       // sample_value, shot_noise, zero pad
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // entry_value
  output logic             out_tuser,  // saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [8:0]  sample_count_r;
  logic [6:0]  vector_length_r;
  logic [6:0]  noise_span_r;
  logic        compat_mode_r;
  logic        prewhiten_r;

  logic [7:0]  sidx;
  logic [5:0]  eidx, cidx;
  logic [31:0] sval, snoise;
  logic        accept, cfg_we;
  logic [32:0] diff;
  logic [31:0] wdata;

  scov_pkg::cfg_t cfg;
  scov_pkg::res_t res;
  logic           eng_idle, res_valid, res_ack;
  logic [scov_pkg::ADDR_W-1:0] raddr;
  logic [31:0]    rdata;

  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;
  logic        out_tuser_r;

  assign sidx   = in_tdata[7:0];
  assign eidx   = in_tdata[13:8];
  assign cidx   = in_tdata[19:14];
  assign sval   = in_tdata[51:20];
  assign snoise = in_tdata[83:52];

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= 9'd2;
      vector_length_r <= 7'd1;
      noise_span_r    <= 7'd0;
      compat_mode_r   <= 1'b1;
      prewhiten_r     <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        scov_pkg::REG_SAMPLE_COUNT:  sample_count_r  <= pwdata[8:0];
        scov_pkg::REG_VECTOR_LENGTH: vector_length_r <= pwdata[6:0];
        scov_pkg::REG_NOISE_SPAN:    noise_span_r    <= pwdata[6:0];
        scov_pkg::REG_COMPAT_MODE:   compat_mode_r   <= pwdata[0];
        scov_pkg::REG_PREWHITEN:     prewhiten_r     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      scov_pkg::REG_SAMPLE_COUNT:  prdata = 32'(sample_count_r);
      scov_pkg::REG_VECTOR_LENGTH: prdata = 32'(vector_length_r);
      scov_pkg::REG_NOISE_SPAN:    prdata = 32'(noise_span_r);
      scov_pkg::REG_COMPAT_MODE:   prdata = 32'(compat_mode_r);
      scov_pkg::REG_PREWHITEN:     prdata = 32'(prewhiten_r);
      default:                     prdata = '0;
    endcase
  end

  // clamp sample count and vector length into range
  always_comb begin
    if (sample_count_r < 9'd2) begin
      cfg.n = 9'd2;
    end else if (sample_count_r > 9'(scov_pkg::MAX_SAMPLES)) begin
      cfg.n = 9'(scov_pkg::MAX_SAMPLES);
    end else begin
      cfg.n = sample_count_r;
    end
    if (vector_length_r == 7'd0) begin
      cfg.len = 7'd1;
    end else if (vector_length_r > 7'(scov_pkg::MAX_LENGTH)) begin
      cfg.len = 7'(scov_pkg::MAX_LENGTH);
    end else begin
      cfg.len = vector_length_r;
    end
    cfg.compat    = compat_mode_r;
    cfg.prewhiten = prewhiten_r;
  end

  assign in_tready = eng_idle;
  assign accept    = in_tvalid && in_tready;

  // shot noise removal on elements below noise_span, with saturation to 32 bits
  assign diff  = {sval[31], sval} -
                 ((7'(eidx) < noise_span_r) ? {snoise[31], snoise} : 33'd0);
  assign wdata = (diff[32] != diff[31]) ? (diff[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                        : diff[31:0];

  scov_store u_store (
    .clk   (clk),
    .we    (accept && in_tuser == scov_pkg::FUNC_LOAD),
    .waddr ({sidx, eidx}),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  scov_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept && in_tuser == scov_pkg::FUNC_QUERY),
    .row       (eidx),
    .col       (cidx),
    .cfg       (cfg),
    .idle      (eng_idle),
    .raddr     (raddr),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ack   (res_ack)
  );

  assign res_ack = res_valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ack) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_tdata_r <= res.value;
      out_tuser_r <= res.sat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

// ----- hdl/scov_chk.sv -----
// ----------------------------------------------------------------------------
// scov_chk
// port-level checks of the sample covariance engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scov_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tuser
);

  // output empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // a query closes the input until its result is out
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input open right after a query");

  // a load leaves the input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("input closed after a load");

  // a new result only comes out of a running query
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a running query");

endmodule

bind sample_covariance_engine_top scov_chk u_scov_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
